/* rtl/core/csbs_pkg.sv */
// Package for the circular spectrum box smoother.
// Holds frame geometry, field widths and the sequencer state type.
// No dependencies.
package csbs_pkg;

  // frame geometry (power-of-two length)
  localparam int FRAME_LEN = 512;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int SHIFT     = $clog2(FRAME_LEN);

  // word field widths
  localparam int BIN_W = 9;
  localparam int MAG_W = 24;
  localparam int RAD_W = 7;

  // window count holds up to 2*max radius; sum grows by that many bits
  localparam int CNT_W = RAD_W + 1;
  localparam int SUM_W = MAG_W + CNT_W;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(10);
  localparam logic [MAG_W-1:0] MAG_MAX      = {MAG_W{1'b1}};

  // input function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } csbs_state_t;

endpackage

/* rtl/core/csbs_if.sv */
// Valid/ready channel interfaces for the smoother's input and result words.
// Depends on csbs_pkg for field widths.
interface csbs_in_if;
  import csbs_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [BIN_W-1:0] bin_index;
  logic [MAG_W-1:0] magnitude;

  modport source (output valid, func, bin_index, magnitude, input ready);
  modport sink   (input valid, func, bin_index, magnitude, output ready);
endinterface

interface csbs_out_if;
  import csbs_pkg::*;
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] result_index;
  logic [MAG_W-1:0] smoothed_value;

  modport source (output valid, result_index, smoothed_value, input ready);
  modport sink   (input valid, result_index, smoothed_value, output ready);
endinterface

/* rtl/core/circular_spectrum_box_smoother_core.sv */
// Circular spectrum box smoother: frame store, window sequencer, one accumulator.
// Depends on csbs_pkg and the channel interfaces in csbs_if.sv.
//
//  channel   dir  word fields                          handshake
//  in_item   in   func, bin_index, magnitude           valid/ready
//  out_item  out  result_index, smoothed_value         valid/ready
//  cfg       in   cfg_wr_en, cfg_wr_data (radius)      write enable only
//
// A load is taken while idle and leaves the sequencer idle. A query sweeps
// the window with one store read per cycle through the single read port
// into one shared accumulator, then drains and posts its result.
// Reset is synchronous and sets the radius to 10; the store is not cleared.
// A new word is accepted while a result waits in the output register; a
// finished query holds in its last step until that register is free.
module circular_spectrum_box_smoother_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [csbs_pkg::RAD_W-1:0]  cfg_wr_data,
  csbs_in_if.sink                     in_item,
  csbs_out_if.source                  out_item
);
  import csbs_pkg::*;

  csbs_state_t             state, state_next;
  logic [RAD_W-1:0]        radius;
  logic [IDX_W-1:0]        addr;
  logic [IDX_W-1:0]        qidx;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        total;
  logic [SUM_W-1:0]        sum;
  logic [MAG_W-1:0]        rd_data;
  logic                    rd_vld;
  logic [MAG_W-1:0]        mem [FRAME_LEN];

  logic                    in_acc;
  logic                    out_free;
  logic [IDX_W-1:0]        in_idx;
  logic [SUM_W-1:0]        shifted;
  logic [MAG_W-1:0]        sat_val;

  assign in_acc   = in_item.valid && in_item.ready;
  assign out_free = !out_item.valid || out_item.ready;
  assign in_idx   = IDX_W'(in_item.bin_index);
  assign total    = {radius, 1'b0};

  // divide by frame length, saturate to the field
  assign shifted = sum >> SHIFT;
  assign sat_val = (shifted > SUM_W'(MAG_MAX)) ? MAG_MAX : MAG_W'(shifted);

  // radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  // frame store: write on load, registered read of the sweep address
  always_ff @(posedge clk) begin
    if (in_acc && in_item.func == FUNC_LOAD) begin
      mem[in_idx] <= in_item.magnitude;
    end
    rd_data <= mem[addr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and input ready
  always_comb begin
    state_next    = state;
    in_item.ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_item.ready = 1'b1;
        if (in_acc && in_item.func == FUNC_QUERY) begin
          state_next = (radius == '0) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt == total - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sweep address, count and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_RUN);
    end
    if (state == ST_IDLE && in_acc) begin
      qidx <= in_idx;
      addr <= in_idx - IDX_W'(radius);
      cnt  <= '0;
      sum  <= '0;
    end else begin
      if (state == ST_RUN) begin
        addr <= addr + IDX_W'(1);
        cnt  <= cnt + CNT_W'(1);
      end
      if (rd_vld) begin
        sum <= sum + SUM_W'(rd_data);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_item.valid <= 1'b1;
    end else if (out_item.ready) begin
      out_item.valid <= 1'b0;
    end
    if (state == ST_FINISH && out_free) begin
      out_item.result_index   <= BIN_W'(qidx);
      out_item.smoothed_value <= sat_val;
    end
  end

  // the sweep never runs past the window
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt < total))
    else $error("window sweep past its end");

  // a new result only comes from the final step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_item.valid) |-> $past(state == ST_FINISH))
    else $error("result posted outside final step");

  // a load finishes in the cycle it is accepted
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.func == FUNC_LOAD) |=> (state == ST_IDLE))
    else $error("load left the sequencer busy");

  // read data is only accumulated right after a sweep cycle
  assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_RUN || state == ST_DRAIN))
    else $error("stray store read accumulated");

endmodule
